FILE: src/four_level_page_table_walker_defines.svh
// assertion macros for the four-level page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication
`define PTW4_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTW4_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ptw4_pkg.sv
// shared types, constants and helpers of the four-level page table walker
`default_nettype none

package ptw4_pkg;

   localparam int FRAMES_DEFAULT = 64;
   localparam int SLOT_W         = 9;
   localparam int SLOTS          = 512;
   localparam int VA_W           = 48;
   localparam int PA_W           = 52;
   localparam int ENTRY_W        = 64;
   localparam int FRAME_IN_W     = 6;
   localparam int TFRAME_W       = 40;
   localparam int OFFSET_W       = 12;

   localparam int PTE_P    = 0;
   localparam int PTE_U    = 2;
   localparam int PTE_H    = 7;
   localparam int ADDR_LO  = 12;
   localparam int ADDR_HI  = 51;

   localparam logic [1:0] LVL_TOP  = 2'd3;
   localparam logic [1:0] LVL_PD   = 2'd1;
   localparam logic [1:0] LVL_LEAF = 2'd0;

   typedef enum logic [1:0] {
      CMD_WRITE     = 2'd0,
      CMD_TRANSLATE = 2'd1,
      CMD_USER      = 2'd2,
      CMD_UNMAP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   // table slot of a virtual address; lvl 3 is the top level, 0 the leaf
   function automatic logic [SLOT_W-1:0] va_slot(logic [VA_W-1:0] va, logic [1:0] lvl);
      logic [SLOT_W-1:0] s;
      unique case (lvl)
         2'd3:    s = va[47:39];
         2'd2:    s = va[38:30];
         2'd1:    s = va[29:21];
         default: s = va[20:12];
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: src/ptw4_store.sv
// table store with one read port, one write port and registered read data
`default_nettype none

module ptw4_store #(
   parameter int DEPTH  = ptw4_pkg::FRAMES_DEFAULT * ptw4_pkg::SLOTS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [ptw4_pkg::ENTRY_W-1:0]  rd_data,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [ptw4_pkg::ENTRY_W-1:0]  wr_data
);
   import ptw4_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/ptw4_walk.sv
// command sequencer: walks the four table levels through the store
`default_nettype none
`include "four_level_page_table_walker_defines.svh"

module ptw4_walk #(
   parameter int FRAMES  = ptw4_pkg::FRAMES_DEFAULT,
   parameter int FRAME_W = $clog2(FRAMES),
   parameter int ADDR_W  = FRAME_W + ptw4_pkg::SLOT_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            store_ready,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [ptw4_pkg::FRAME_IN_W-1:0] req_root_frame,
   input  wire logic [ptw4_pkg::VA_W-1:0]       req_virt_addr,
   input  wire logic [ptw4_pkg::FRAME_IN_W-1:0] req_entry_frame,
   input  wire logic [ptw4_pkg::SLOT_W-1:0]     req_entry_index,
   input  wire logic [ptw4_pkg::ENTRY_W-1:0]    req_entry_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [ptw4_pkg::PA_W-1:0]       rsp_phys_addr,
   output logic                                 rsp_ok,
   output logic                                 rsp_beyond_store,
   output logic                                 rd_en,
   output logic      [ADDR_W-1:0]               rd_addr,
   input  wire logic [ptw4_pkg::ENTRY_W-1:0]    rd_data,
   output logic                                 wr_en,
   output logic      [ADDR_W-1:0]               wr_addr,
   output logic      [ptw4_pkg::ENTRY_W-1:0]    wr_data
);
   import ptw4_pkg::*;

   localparam logic [TFRAME_W-1:0] FRAMES_L = TFRAME_W'(FRAMES);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic [VA_W-1:0]    va_ff;
   logic [1:0]         level_ff, level_in;

   logic               rsp_valid_ff;
   logic [PA_W-1:0]    rsp_pa_ff;
   logic               rsp_ok_ff;
   logic               rsp_beyond_ff;

   logic [PA_W-1:0]    res_pa_ff;
   logic               res_ok_ff;
   logic               res_beyond_ff;

   logic               accept;
   logic               out_free;
   logic               out_load;
   logic               fin;
   logic [PA_W-1:0]    fin_pa;
   logic               fin_ok;
   logic               fin_beyond;
   logic               advance;

   assign req_stall = (state_ff != ST_IDLE) || !store_ready;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = out_free && (fin || (state_ff == ST_HOLD));

   // walk decisions and store accesses
   always_comb begin
      logic [TFRAME_W-1:0] root_ext;
      logic [TFRAME_W-1:0] ef_ext;
      logic [TFRAME_W-1:0] tf;
      logic                pres;
      logic                user;
      logic                huge;
      root_ext   = TFRAME_W'(req_root_frame);
      ef_ext     = TFRAME_W'(req_entry_frame);
      tf         = rd_data[ADDR_HI:ADDR_LO];
      pres       = rd_data[PTE_P];
      user       = rd_data[PTE_U];
      huge       = rd_data[PTE_H];
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      fin        = 1'b0;
      fin_pa     = '0;
      fin_ok     = 1'b0;
      fin_beyond = 1'b0;
      advance    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cmd_type'(req_cmd) == CMD_WRITE) begin
                  fin = 1'b1;
                  if (ef_ext < FRAMES_L) begin
                     wr_en   = 1'b1;
                     wr_addr = {ef_ext[FRAME_W-1:0], req_entry_index};
                     wr_data = req_entry_value;
                     fin_ok  = 1'b1;
                  end else begin
                     fin_beyond = 1'b1;
                  end
               end else if (root_ext == '0) begin
                  fin = 1'b1;
               end else if (root_ext >= FRAMES_L) begin
                  fin        = 1'b1;
                  fin_beyond = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = {root_ext[FRAME_W-1:0], va_slot(req_virt_addr, LVL_TOP)};
               end
            end
         end
         ST_WALK: begin
            if (level_ff == LVL_LEAF) begin
               fin = 1'b1;
               if (cmd_ff == CMD_TRANSLATE) begin
                  if (pres) begin
                     fin_pa = {rd_data[ADDR_HI:ADDR_LO], va_ff[OFFSET_W-1:0]};
                     fin_ok = 1'b1;
                  end
               end else begin
                  fin_ok = pres && user;
               end
            end else if ((cmd_ff == CMD_USER) && (!pres || !user)) begin
               fin = 1'b1;
            end else if ((cmd_ff == CMD_USER) && huge) begin
               fin    = 1'b1;
               fin_ok = 1'b1;
            end else if ((cmd_ff != CMD_USER) && (!pres || huge)) begin
               fin = 1'b1;
            end else if (tf == '0) begin
               fin = 1'b1;
            end else if (tf >= FRAMES_L) begin
               fin        = 1'b1;
               fin_beyond = 1'b1;
            end else if ((cmd_ff == CMD_UNMAP) && (level_ff == LVL_PD)) begin
               wr_en   = 1'b1;
               wr_addr = {tf[FRAME_W-1:0], va_slot(va_ff, LVL_LEAF)};
               fin     = 1'b1;
               fin_ok  = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = {tf[FRAME_W-1:0], va_slot(va_ff, level_ff - 2'd1)};
               advance = 1'b1;
            end
         end
         ST_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               level_in = LVL_TOP;
               if (!fin) begin
                  state_in = ST_WALK;
               end else if (!out_free) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_WALK: begin
            if (advance) begin
               level_in = level_ff - 2'd1;
            end else if (fin) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= LVL_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         va_ff  <= req_virt_addr;
      end
      if (fin && !out_free) begin
         res_pa_ff     <= fin_pa;
         res_ok_ff     <= fin_ok;
         res_beyond_ff <= fin_beyond;
      end
      if (out_load) begin
         if (state_ff == ST_HOLD) begin
            rsp_pa_ff     <= res_pa_ff;
            rsp_ok_ff     <= res_ok_ff;
            rsp_beyond_ff <= res_beyond_ff;
         end else begin
            rsp_pa_ff     <= fin_pa;
            rsp_ok_ff     <= fin_ok;
            rsp_beyond_ff <= fin_beyond;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phys_addr    = rsp_pa_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_beyond_store = rsp_beyond_ff;

   `PTW4_ASSERT_IMP(a_walk_has_read, clock, reset, state_ff == ST_WALK, $past(rd_en), "walk step without a store read")
   `PTW4_ASSERT_IMP(a_rd_wr_excl, clock, reset, rd_en, !wr_en, "store read and write in one cycle")
   `PTW4_ASSERT_IMP(a_walk_write_unmap, clock, reset, wr_en && (state_ff == ST_WALK), (cmd_ff == CMD_UNMAP) && (level_ff == LVL_PD), "walk write outside unmap")
   `PTW4_ASSERT_IMP(a_hold_full, clock, reset, state_ff == ST_HOLD, rsp_valid_ff, "held result with empty output register")
   `PTW4_ASSERT_NEXT(a_fin_blocked_hold, clock, reset, fin && !out_free, state_ff == ST_HOLD, "blocked result not held")

endmodule

`default_nettype wire

FILE: src/four_level_page_table_walker.sv
// four-level page table walker: clear sequencer, table store and walk sequencer
// a write or a failing root check finishes at accept, with no store read
// a walk reads the store once per level it visits; an unmap writes the leaf entry instead
// a new transaction is taken only while the sequencer is idle, once the last result is in the output register
// reset: req_stall stays high while the clearing pass zeroes every store entry
`default_nettype none
`include "four_level_page_table_walker_defines.svh"

module four_level_page_table_walker #(
   parameter int FRAMES = ptw4_pkg::FRAMES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [ptw4_pkg::FRAME_IN_W-1:0] req_root_frame,
   input  wire logic [ptw4_pkg::VA_W-1:0]       req_virt_addr,
   input  wire logic [ptw4_pkg::FRAME_IN_W-1:0] req_entry_frame,
   input  wire logic [ptw4_pkg::SLOT_W-1:0]     req_entry_index,
   input  wire logic [ptw4_pkg::ENTRY_W-1:0]    req_entry_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [ptw4_pkg::PA_W-1:0]       rsp_phys_addr,
   output logic                                 rsp_ok,
   output logic                                 rsp_beyond_store
);
   import ptw4_pkg::*;

   localparam int FRAME_W = $clog2(FRAMES);
   localparam int ADDR_W  = FRAME_W + SLOT_W;
   localparam int DEPTH   = FRAMES * SLOTS;

   logic                clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   logic                wk_rd_en;
   logic [ADDR_W-1:0]   wk_rd_addr;
   logic [ENTRY_W-1:0]  st_rd_data;
   logic                wk_wr_en;
   logic [ADDR_W-1:0]   wk_wr_addr;
   logic [ENTRY_W-1:0]  wk_wr_data;

   logic                st_wr_en;
   logic [ADDR_W-1:0]   st_wr_addr;
   logic [ENTRY_W-1:0]  st_wr_data;

   // clearing pass after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign st_wr_en   = clr_busy_ff || wk_wr_en;
   assign st_wr_addr = clr_busy_ff ? clr_addr_ff : wk_wr_addr;
   assign st_wr_data = clr_busy_ff ? '0 : wk_wr_data;

   ptw4_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (wk_rd_en),
      .rd_addr (wk_rd_addr),
      .rd_data (st_rd_data),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data)
   );

   ptw4_walk #(
      .FRAMES  (FRAMES),
      .FRAME_W (FRAME_W),
      .ADDR_W  (ADDR_W)
   ) u_walk (
      .clock            (clock),
      .reset            (reset),
      .store_ready      (!clr_busy_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_root_frame   (req_root_frame),
      .req_virt_addr    (req_virt_addr),
      .req_entry_frame  (req_entry_frame),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_phys_addr    (rsp_phys_addr),
      .rsp_ok           (rsp_ok),
      .rsp_beyond_store (rsp_beyond_store),
      .rd_en            (wk_rd_en),
      .rd_addr          (wk_rd_addr),
      .rd_data          (st_rd_data),
      .wr_en            (wk_wr_en),
      .wr_addr          (wk_wr_addr),
      .wr_data          (wk_wr_data)
   );

   `PTW4_ASSERT_IMP(a_clear_no_walk, clock, reset, clr_busy_ff, !wk_wr_en && !wk_rd_en, "store access while clearing")
   `PTW4_ASSERT_IMP(a_clear_stall, clock, reset, clr_busy_ff, req_stall, "transaction taken while clearing")
   `PTW4_ASSERT_NEXT(a_clear_end, clock, reset, clr_busy_ff && (clr_addr_ff == ADDR_W'(DEPTH - 1)), !clr_busy_ff, "clearing pass overran")

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench of the four-level page table walker
module tb;
   import ptw4_pkg::*;

   localparam int FRAMES       = FRAMES_DEFAULT;
   localparam int ITEM_TARGET  = 550;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [PA_W-1:0] phys_addr;
      logic            ok;
      logic            beyond_store;
   } walk_result_type;

   typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} stall_mode_type;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_cmd         = CMD_WRITE;
   logic [FRAME_IN_W-1:0] req_root_frame  = '0;
   logic [VA_W-1:0]       req_virt_addr   = '0;
   logic [FRAME_IN_W-1:0] req_entry_frame = '0;
   logic [SLOT_W-1:0]     req_entry_index = '0;
   logic [ENTRY_W-1:0]    req_entry_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [PA_W-1:0]       rsp_phys_addr;
   logic                  rsp_ok;
   logic                  rsp_beyond_store;

   bit [ENTRY_W-1:0] table_mirror [FRAMES*SLOTS];
   walk_result_type  expected_walks [$];

   int             error_count  = 0;
   int             sent_count   = 0;
   int             burst_left   = 0;
   int             cycle_count  = 0;
   int             hold_left    = 0;
   int             mode_left    = 0;
   bit             hold_request = 1'b0;
   stall_mode_type stall_mode   = FLOW_FREE;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   four_level_page_table_walker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_root_frame   (req_root_frame),
      .req_virt_addr    (req_virt_addr),
      .req_entry_frame  (req_entry_frame),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_phys_addr    (rsp_phys_addr),
      .rsp_ok           (rsp_ok),
      .rsp_beyond_store (rsp_beyond_store)
   );

   function automatic logic [SLOT_W-1:0] level_slot(logic [VA_W-1:0] va, int lvl);
      return va[ADDR_LO + SLOT_W * (lvl - 1) +: SLOT_W];
   endfunction

   // walks the mirrored tables and applies writes and unmaps to them
   function automatic walk_result_type predict_walk(cmd_type cmd, logic [FRAME_IN_W-1:0] root,
         logic [VA_W-1:0] va, logic [FRAME_IN_W-1:0] ef, logic [SLOT_W-1:0] ei,
         logic [ENTRY_W-1:0] ev);
      walk_result_type     r;
      logic [TFRAME_W-1:0] frame;
      logic [ENTRY_W-1:0]  pte;
      bit                  alive;
      bit                  done;
      int                  lvl;
      int                  idx;
      r = '0;
      if (cmd == CMD_WRITE) begin
         if (ef < FRAMES) begin
            table_mirror[int'(ef) * SLOTS + int'(ei)] = ev;
            r.ok = 1'b1;
         end else begin
            r.beyond_store = 1'b1;
         end
         return r;
      end
      frame = TFRAME_W'(root);
      alive = 1'b1;
      done  = 1'b0;
      if (frame == 0) begin
         alive = 1'b0;
      end else if (frame >= FRAMES) begin
         alive = 1'b0;
         r.beyond_store = 1'b1;
      end
      for (lvl = 4; lvl >= 2 && alive && !done; lvl--) begin
         pte = table_mirror[int'(frame) * SLOTS + int'(level_slot(va, lvl))];
         if (!pte[PTE_P]) begin
            alive = 1'b0;
         end else if (cmd == CMD_USER) begin
            if (!pte[PTE_U]) begin
               alive = 1'b0;
            end else if (pte[PTE_H]) begin
               r.ok = 1'b1;
               done = 1'b1;
            end
         end else if (pte[PTE_H]) begin
            alive = 1'b0;
         end
         if (alive && !done) begin
            frame = pte[ADDR_HI:ADDR_LO];
            if (frame == 0) begin
               alive = 1'b0;
            end else if (frame >= FRAMES) begin
               alive = 1'b0;
               r.beyond_store = 1'b1;
            end
         end
      end
      if (alive && !done) begin
         idx = int'(frame) * SLOTS + int'(level_slot(va, 1));
         pte = table_mirror[idx];
         case (cmd)
            CMD_TRANSLATE: begin
               if (pte[PTE_P]) begin
                  r.phys_addr = {pte[ADDR_HI:ADDR_LO], va[OFFSET_W-1:0]};
                  r.ok = 1'b1;
               end
            end
            CMD_USER: r.ok = pte[PTE_P] & pte[PTE_U];
            default: begin
               table_mirror[idx] = '0;
               r.ok = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      walk_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_walks.push_back(predict_walk(cmd_type'(req_cmd), req_root_frame,
               req_virt_addr, req_entry_frame, req_entry_index, req_entry_value));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_walks.size() == 0) begin
               $error("response with no transaction pending");
               error_count++;
            end else begin
               want = expected_walks.pop_front();
               if (rsp_phys_addr !== want.phys_addr) begin
                  $error("phys_addr expected %h actual %h", want.phys_addr, rsp_phys_addr);
                  error_count++;
               end
               if (rsp_ok !== want.ok) begin
                  $error("ok expected %b actual %b", want.ok, rsp_ok);
                  error_count++;
               end
               if (rsp_beyond_store !== want.beyond_store) begin
                  $error("beyond_store expected %b actual %b", want.beyond_store,
                     rsp_beyond_store);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            FLOW_FREE:  rsp_stall <= 1'b0;
            FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:    rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic send_item(cmd_type cmd, logic [FRAME_IN_W-1:0] root, logic [VA_W-1:0] va,
         logic [FRAME_IN_W-1:0] frame, logic [SLOT_W-1:0] slot, logic [ENTRY_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_root_frame  <= root;
      req_virt_addr   <= va;
      req_entry_frame <= frame;
      req_entry_index <= slot;
      req_entry_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      sent_count++;
   endtask

   function automatic logic [ENTRY_W-1:0] make_pte(logic [TFRAME_W-1:0] target, bit present,
         bit user, bit huge);
      logic [ENTRY_W-1:0] v;
      v = {$urandom, $urandom};
      v[ADDR_HI:ADDR_LO] = target;
      v[PTE_P] = present;
      v[PTE_U] = user;
      v[PTE_H] = huge;
      return v;
   endfunction

   task automatic write_pte(logic [FRAME_IN_W-1:0] frame, logic [SLOT_W-1:0] slot,
         logic [ENTRY_W-1:0] value);
      send_item(CMD_WRITE, FRAME_IN_W'($urandom), VA_W'({$urandom, $urandom}), frame, slot,
         value);
   endtask

   task automatic send_walk(cmd_type cmd, logic [FRAME_IN_W-1:0] root, logic [VA_W-1:0] va);
      send_item(cmd, root, va, FRAME_IN_W'($urandom), SLOT_W'($urandom),
         ENTRY_W'({$urandom, $urandom}));
   endtask

   // builds one four-level path with occasional defects, then probes it
   task automatic random_walk_scenario();
      logic [VA_W-1:0]       va;
      logic [VA_W-1:0]       probe;
      logic [FRAME_IN_W-1:0] root;
      logic [FRAME_IN_W-1:0] here;
      logic [TFRAME_W-1:0]   next;
      cmd_type               cmd;
      int                    lvl;
      int                    roll;
      bit                    huge;
      va   = VA_W'({$urandom, $urandom});
      root = ($urandom_range(0, 19) == 0) ? '0 : FRAME_IN_W'($urandom_range(1, FRAMES - 1));
      here = root;
      for (lvl = 4; lvl >= 1; lvl--) begin
         roll = $urandom_range(0, 99);
         huge = (roll >= 6 && roll < 10) || (lvl == 1 && $urandom_range(0, 1) == 1);
         if (lvl == 1) begin
            next = TFRAME_W'({$urandom, $urandom});
         end else if (roll >= 10 && roll < 13) begin
            next = '0;
         end else if (roll >= 13 && roll < 16) begin
            next = TFRAME_W'({$urandom, $urandom}) | TFRAME_W'(FRAMES);
         end else begin
            next = TFRAME_W'($urandom_range(1, FRAMES - 1));
         end
         write_pte(here, level_slot(va, lvl),
            make_pte(next, roll >= 6, $urandom_range(0, 9) != 0, huge));
         if (lvl == 1 || next == 0 || next >= FRAMES) break;
         here = next[FRAME_IN_W-1:0];
      end
      repeat ($urandom_range(1, 4)) begin
         probe = {va[VA_W-1:OFFSET_W], OFFSET_W'($urandom)};
         if ($urandom_range(0, 7) == 0) probe[ADDR_LO +: SLOT_W] = SLOT_W'($urandom);
         roll = $urandom_range(0, 5);
         cmd  = (roll < 3) ? CMD_TRANSLATE : (roll < 5) ? CMD_USER : CMD_UNMAP;
         send_walk(cmd, root, probe);
      end
   endtask

   task automatic test_directed_cases();
      logic [VA_W-1:0] va_top;
      va_top = '1;
      va_top[OFFSET_W-1:0] = 12'h123;
      // null root, then an empty top-level table
      send_walk(CMD_TRANSLATE, '0, '1);
      send_walk(CMD_USER, 6'd63, va_top);
      // full path through the highest slots to the highest page
      write_pte(6'd63, '1, make_pte(40'd5, 1'b1, 1'b1, 1'b0));
      write_pte(6'd5, '1, make_pte(40'd6, 1'b1, 1'b1, 1'b0));
      write_pte(6'd6, '1, make_pte(40'd7, 1'b1, 1'b1, 1'b0));
      write_pte(6'd7, '1, make_pte('1, 1'b1, 1'b1, 1'b1));
      send_walk(CMD_TRANSLATE, 6'd63, va_top);
      send_walk(CMD_USER, 6'd63, va_top);
      send_walk(CMD_UNMAP, 6'd63, va_top);
      send_walk(CMD_TRANSLATE, 6'd63, va_top);
      send_walk(CMD_USER, 6'd63, va_top);
      // null next table
      write_pte(6'd1, '0, make_pte('0, 1'b1, 1'b1, 1'b0));
      send_walk(CMD_TRANSLATE, 6'd1, '0);
      // next table outside the store
      write_pte(6'd2, '0, make_pte(40'd64, 1'b1, 1'b1, 1'b0));
      send_walk(CMD_TRANSLATE, 6'd2, '0);
      send_walk(CMD_USER, 6'd2, '0);
      // huge entry one level down
      write_pte(6'd3, '0, make_pte(40'd4, 1'b1, 1'b1, 1'b0));
      write_pte(6'd4, '0, make_pte(40'd9, 1'b1, 1'b1, 1'b1));
      send_walk(CMD_TRANSLATE, 6'd3, '0);
      send_walk(CMD_USER, 6'd3, '0);
      send_walk(CMD_UNMAP, 6'd3, '0);
      // all-ones entry at the top level
      send_item(CMD_WRITE, '1, '1, 6'd62, '0, '1);
      send_walk(CMD_TRANSLATE, 6'd62, '0);
      send_walk(CMD_USER, 6'd62, '0);
      // user bit cleared at the top level
      write_pte(6'd63, '1, make_pte(40'd5, 1'b1, 1'b0, 1'b0));
      send_walk(CMD_USER, 6'd63, va_top);
      send_item(CMD_WRITE, '0, '0, '0, '0, '0);
   endtask

   task automatic test_random_walks(int target);
      while (sent_count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(cmd_type'($urandom_range(0, 3)), FRAME_IN_W'($urandom),
               VA_W'({$urandom, $urandom}), FRAME_IN_W'($urandom), SLOT_W'($urandom),
               ENTRY_W'({$urandom, $urandom}));
         end else begin
            random_walk_scenario();
         end
      end
   endtask

   // long receiver hold-off while the sender keeps offering back to back
   task automatic test_backpressure();
      int start;
      start = sent_count;
      hold_request = 1'b1;
      burst_left = 1000;
      while (sent_count < start + 30) random_walk_scenario();
      burst_left = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_walks(ITEM_TARGET / 2);
      test_backpressure();
      test_random_walks(ITEM_TARGET);
      req_valid <= 1'b0;
      while (expected_walks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
